/* design/srrw_pkg.sv */
package srrw_pkg;

  localparam int WINDOW_MAX      = 32;
  localparam int MAX_FRAMES      = 4096;
  localparam int FRAME_BYTES_LOG2 = 10;

  localparam int SEQ_W   = 12;
  localparam int PLEN_W  = 11;
  localparam int WS_W    = 6;
  localparam int FPB_W   = 13;
  localparam int OFFS_W  = 22;
  localparam int LEN_W   = 23;
  localparam int CFG_W   = 13;
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic {
    REG_RX_WIN = 1'b0,
    REG_FRAMES_PER_BUFFER = 1'b1
  } srrw_reg_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_num;
    logic              bad_frame;
    logic              last_frame;
    logic [PLEN_W-1:0] payload_len;
  } srrw_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  ack_seq;
    logic              ack_negative;
    logic              store_strobe;
    logic [OFFS_W-1:0] store_offset;
    logic              buffer_complete;
    logic [LEN_W-1:0]  buffer_length;
    logic              transfer_done;
  } srrw_result_t;

endpackage

/* design/srrw_in_reg.sv */
module srrw_in_reg import srrw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  srrw_item_t in_item,
  input  logic       down_ready,
  output logic       item_fire,
  output srrw_item_t item
);

  logic       valid_r;
  logic       valid_nxt;
  srrw_item_t item_r;

  assign item_fire = valid_r && down_ready;
  assign in_ready  = !valid_r || down_ready;
  assign item      = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* design/srrw_window.sv */
module srrw_window import srrw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  srrw_reg_t        cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             item_fire,
  input  srrw_item_t       item,
  output srrw_result_t     result
);

  logic [WS_W-1:0]         rx_win_r;
  logic [FPB_W-1:0]        frames_r;
  logic signed [FPB_W-1:0] last_in_order_r, last_in_order_nxt;
  logic [WINDOW_MAX-1:0]   flags_r, flags_nxt;
  logic [FPB_W-1:0]        frame_limit_r, frame_limit_nxt;
  logic [LEN_W-1:0]        pending_r, pending_nxt;
  logic                    ending_r, ending_nxt;
  logic                    finished_r, finished_nxt;

  logic [WS_W-1:0]         rws;
  logic [FPB_W-1:0]        eff_frames_run, eff_frames_cfg, restart_frames;
  logic [WINDOW_MAX-1:0]   mask, flags_m, flags_up;
  logic signed [14:0]      lio_s, seq_s, fl_s, lio_after;
  logic [CNT_W-1:0]        tones;
  logic [CNT_W-1:0]        shift;
  logic [4:0]              idx;
  logic [OFFS_W-1:0]       offset;
  logic                    accept, in_order, ahead, strobe, complete;
  logic signed [FPB_W-1:0] lio_up;
  logic [FPB_W-1:0]        fl_up;
  logic [LEN_W-1:0]        pend_up;
  logic                    end_up;
  logic                    at_start;

  function automatic logic [FPB_W-1:0] clamp_frames(input logic [FPB_W-1:0] f);
    logic [FPB_W-1:0] r;
    r = f;
    if (f == '0) r = FPB_W'(1);
    if (f > FPB_W'(MAX_FRAMES)) r = FPB_W'(MAX_FRAMES);
    return r;
  endfunction

  always_comb begin
    rws = rx_win_r;
    if (rx_win_r == '0) rws = WS_W'(1);
    if (rx_win_r > WS_W'(WINDOW_MAX)) rws = WS_W'(WINDOW_MAX);
  end

  assign eff_frames_run = clamp_frames(frames_r);
  assign eff_frames_cfg = clamp_frames(cfg_wdata[FPB_W-1:0]);

  assign mask    = (rws >= WS_W'(WINDOW_MAX)) ? '1 : ((WINDOW_MAX'(1) << rws) - WINDOW_MAX'(1));
  assign flags_m = flags_r & mask;

  assign lio_s  = 15'(last_in_order_r);
  assign seq_s  = signed'({3'b000, item.seq_num});
  assign fl_s   = signed'({2'b00, frame_limit_r});
  assign offset = {item.seq_num, {FRAME_BYTES_LOG2{1'b0}}};
  assign idx    = 5'(seq_s - lio_s - 15'sd1);

  // trailing ones above the next-expected slot, plus one, give the slide length
  always_comb begin
    tones = CNT_W'(WINDOW_MAX - 1);
    for (int i = WINDOW_MAX - 1; i >= 1; i--) begin
      if (!flags_m[i]) tones = CNT_W'(i - 1);
    end
  end
  assign shift = tones + CNT_W'(1);

  assign accept   = !finished_r && !item.bad_frame &&
                    (seq_s <= lio_s + signed'({9'd0, rws})) &&
                    ((seq_s < fl_s) || item.last_frame);
  assign in_order = seq_s == lio_s + 15'sd1;
  assign ahead    = seq_s > lio_s + 15'sd1;

  always_comb begin
    flags_up = flags_m;
    lio_up   = last_in_order_r;
    strobe   = 1'b0;
    fl_up    = frame_limit_r;
    pend_up  = pending_r;
    end_up   = ending_r;
    if (accept) begin
      if (in_order) begin
        strobe   = 1'b1;
        flags_up = (flags_m >> shift) & mask;
        lio_up   = last_in_order_r + signed'(FPB_W'(shift));
      end else if (ahead) begin
        if (!flags_m[idx]) begin
          strobe = 1'b1;
        end
        flags_up[idx] = 1'b1;
      end
      if (item.last_frame) begin
        pend_up = LEN_W'(offset) + LEN_W'(item.payload_len);
        fl_up   = FPB_W'(item.seq_num) + FPB_W'(1);
        end_up  = 1'b1;
      end
    end
  end

  assign lio_after = 15'(lio_up);
  assign complete  = !finished_r &&
                     (lio_after >= signed'({2'b00, fl_up}) - 15'sd1);

  assign at_start = (last_in_order_r == '1) && (flags_r == '0) && !ending_r && !finished_r;
  assign restart_frames = (cfg_wr_en && cfg_addr == REG_FRAMES_PER_BUFFER) ?
                          eff_frames_cfg : eff_frames_run;

  always_comb begin
    last_in_order_nxt = last_in_order_r;
    flags_nxt         = flags_r;
    frame_limit_nxt   = frame_limit_r;
    pending_nxt       = pending_r;
    ending_nxt        = ending_r;
    finished_nxt      = finished_r;
    if (item_fire) begin
      ending_nxt = end_up;
      if (complete) begin
        finished_nxt      = end_up;
        last_in_order_nxt = '1;
        flags_nxt         = '0;
        frame_limit_nxt   = eff_frames_run;
        pending_nxt       = {eff_frames_run, {FRAME_BYTES_LOG2{1'b0}}};
      end else begin
        last_in_order_nxt = lio_up;
        flags_nxt         = flags_up;
        frame_limit_nxt   = fl_up;
        pending_nxt       = pend_up;
      end
    end else if (cfg_wr_en && cfg_addr == REG_FRAMES_PER_BUFFER && at_start) begin
      frame_limit_nxt = restart_frames;
      pending_nxt     = {restart_frames, {FRAME_BYTES_LOG2{1'b0}}};
    end
  end

  always_comb begin
    result.ack_seq         = item.seq_num;
    result.ack_negative    = item.bad_frame;
    result.store_strobe    = strobe;
    result.store_offset    = strobe ? offset : '0;
    result.buffer_complete = complete;
    result.buffer_length   = complete ? pend_up : '0;
    result.transfer_done   = complete && end_up;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_win_r        <= WS_W'(8);
      frames_r        <= FPB_W'(16);
      last_in_order_r <= '1;
      flags_r         <= '0;
      frame_limit_r   <= FPB_W'(16);
      pending_r       <= LEN_W'(16) << FRAME_BYTES_LOG2;
      ending_r        <= 1'b0;
      finished_r      <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_addr == REG_RX_WIN) begin
        rx_win_r <= cfg_wdata[WS_W-1:0];
      end
      if (cfg_wr_en && cfg_addr == REG_FRAMES_PER_BUFFER) begin
        frames_r <= cfg_wdata[FPB_W-1:0];
      end
      last_in_order_r <= last_in_order_nxt;
      flags_r         <= flags_nxt;
      frame_limit_r   <= frame_limit_nxt;
      pending_r       <= pending_nxt;
      ending_r        <= ending_nxt;
      finished_r      <= finished_nxt;
    end
  end

endmodule

/* design/srrw_out_reg.sv */
module srrw_out_reg import srrw_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  srrw_result_t result,
  output logic         can_load,
  output logic         out_valid,
  input  logic         out_ready,
  output srrw_result_t out_result
);

  logic         valid_r;
  logic         valid_nxt;
  srrw_result_t result_r;

  assign can_load   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

/* design/selective_repeat_receive_window_top.sv */
// channel | dir | tdata (low bit up)                                  | tuser        | tlast
// in_     | in  | seq_num[11:0] payload_len[22:12] pad[23]             | bad_frame    | last_frame
// out_    | out | ack_seq[11:0] store_strobe[12] store_offset[34:13]   | ack_negative | transfer_done
//         |     | buffer_complete[35] buffer_length[58:36] pad[63:59]  |              |
// cfg_    | in  | cfg_wr_en, cfg_addr (0 rx window width, 1 frames_per_buffer), cfg_wdata[12:0]
//
// One frame per cycle sustained while out_tready stays high.
// The window slide (trailing-ones count and shift of the 32-bit flag vector) sits
// between the input register and the result register.
// rst_n is synchronous; both pipeline registers come up empty, no clearing pass.
// A stalled result holds the output register; the input register still takes one
// more request, then in_tready drops until the result is taken.
module selective_repeat_receive_window_top import srrw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // seq_num, payload_len
  input  logic                   in_tuser,   // bad_frame
  input  logic                   in_tlast,   // last_frame
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // ack_seq, store_strobe, store_offset,
                                             // buffer_complete, buffer_length
  output logic                   out_tuser,  // ack_negative
  output logic                   out_tlast,  // transfer_done
  input  logic                   cfg_wr_en,
  input  srrw_reg_t              cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  srrw_item_t   in_item, item;
  srrw_result_t result, out_result;
  logic         item_fire, can_load;

  assign in_item.seq_num     = in_tdata[SEQ_W-1:0];
  assign in_item.payload_len = in_tdata[SEQ_W+PLEN_W-1:SEQ_W];
  assign in_item.bad_frame   = in_tuser;
  assign in_item.last_frame  = in_tlast;

  srrw_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .down_ready (can_load),
    .item_fire  (item_fire),
    .item       (item)
  );

  srrw_window u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .item_fire (item_fire),
    .item      (item),
    .result    (result)
  );

  srrw_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (item_fire),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {5'b00000,
                      out_result.buffer_length,
                      out_result.buffer_complete,
                      out_result.store_offset,
                      out_result.store_strobe,
                      out_result.ack_seq};
  assign out_tuser = out_result.ack_negative;
  assign out_tlast = out_result.transfer_done;

`ifndef SYNTH
  ap_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while result side is free");

  ap_done_with_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tdata[35])
    else $error("transfer done without buffer release");

  ap_no_store_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !(out_tvalid && out_tdata[12]))
    else $error("store request after end of transfer");

  ap_offset_only_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[12]) |-> (out_tdata[34:13] == '0))
    else $error("store offset without store strobe");
`endif

endmodule

/* sim/selective_repeat_receive_window_top_tb.sv */
`timescale 1ns / 100ps

module selective_repeat_receive_window_top_tb;
  import srrw_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 190;
  localparam int WIN_SET [PHASES] = '{8, 1, 32, 0, 63, 5, 32, 2, 32, 12};
  localparam int FPB_SET [PHASES] = '{16, 1, 40, 0, 20, 3, 1, 7, 64, 12};

  typedef enum logic {
    ROW_FRAME,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    srrw_reg_t        sel;
    logic [CFG_W-1:0] value;
    srrw_item_t       frame;
    logic             typed;
    srrw_result_t     want;
  } step_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  srrw_reg_t cfg_addr = REG_RX_WIN;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // window state as the block should hold it
  logic [WS_W-1:0] win_reg;
  logic [FPB_W-1:0] fpb_reg;
  int last_in_order;
  int frame_limit;
  logic [WINDOW_MAX-1:0] rx_flags;
  logic [LEN_W-1:0] pending_len;
  logic end_mark_seen;
  logic xfer_finished;

  srrw_result_t pending_acks[$];
  srrw_result_t seen_res;
  step_row_t script[$];
  int err_count = 0;
  int quiet = 0;
  int stall_left = 0;
  int rx_draw;
  logic calm = 1'b0;

  selective_repeat_receive_window_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int clamp_window(logic [WS_W-1:0] v);
    int w;
    w = int'(v);
    if (w < 1) w = 1;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    return w;
  endfunction

  function automatic int clamp_frames(logic [FPB_W-1:0] v);
    int f;
    f = int'(v);
    if (f < 1) f = 1;
    if (f > MAX_FRAMES) f = MAX_FRAMES;
    return f;
  endfunction

  function automatic void restart_window();
    last_in_order = -1;
    rx_flags = '0;
    frame_limit = clamp_frames(fpb_reg);
    pending_len = LEN_W'(frame_limit) << FRAME_BYTES_LOG2;
  endfunction

  function automatic void apply_cfg(srrw_reg_t sel, logic [CFG_W-1:0] val);
    if (sel == REG_RX_WIN) begin
      win_reg = val[WS_W-1:0];
    end else begin
      fpb_reg = val[FPB_W-1:0];
      // untouched window picks up the new buffer size at once
      if (last_in_order == -1 && rx_flags == '0 && !end_mark_seen && !xfer_finished)
        restart_window();
    end
  endfunction

  function automatic srrw_result_t window_step(srrw_item_t f);
    srrw_result_t r;
    logic [WINDOW_MAX-1:0] wmask;
    logic [LEN_W-1:0] off;
    int win;
    int s;
    int slide;
    int idx;
    win = clamp_window(win_reg);
    wmask = (win >= WINDOW_MAX) ? '1 : WINDOW_MAX'((64'd1 << win) - 64'd1);
    s = int'(f.seq_num);
    off = LEN_W'(f.seq_num) << FRAME_BYTES_LOG2;
    r = '0;
    r.ack_seq = f.seq_num;
    r.ack_negative = f.bad_frame;
    rx_flags &= wmask;
    if (!xfer_finished && !f.bad_frame && s <= last_in_order + win &&
        (s < frame_limit || f.last_frame)) begin
      if (s == last_in_order + 1) begin
        slide = 1;
        r.store_strobe = 1'b1;
        while (slide < win && rx_flags[slide]) slide++;
        rx_flags = (rx_flags >> slide) & wmask;
        last_in_order += slide;
      end else if (s > last_in_order + 1) begin
        idx = s - last_in_order - 1;
        if (!rx_flags[idx]) begin
          rx_flags[idx] = 1'b1;
          r.store_strobe = 1'b1;
        end
      end
      if (f.last_frame) begin
        pending_len = off + LEN_W'(f.payload_len);
        frame_limit = s + 1;
        end_mark_seen = 1'b1;
      end
    end
    if (r.store_strobe) r.store_offset = off[OFFS_W-1:0];
    if (!xfer_finished && last_in_order >= frame_limit - 1) begin
      r.buffer_complete = 1'b1;
      r.buffer_length = pending_len;
      r.transfer_done = end_mark_seen;
      xfer_finished = end_mark_seen;
      restart_window();
    end
    return r;
  endfunction

  // mostly in-window frames near the window base, plus old, far and random ones;
  // end marks only where they cannot end the transfer, until it has ended
  function automatic srrw_item_t pick_frame();
    srrw_item_t f;
    int win;
    int base;
    int s;
    int k;
    win = clamp_window(win_reg);
    base = last_in_order + 1;
    k = $urandom_range(0, 99);
    if (k < 35) s = base;
    else if (k < 70) s = base + $urandom_range(0, win - 1);
    else if (k < 78) s = base - 1 - $urandom_range(0, 3);
    else if (k < 90) s = base + win + $urandom_range(0, 3);
    else s = $urandom_range(0, 4095);
    f.seq_num = s[SEQ_W-1:0];
    f.bad_frame = ($urandom_range(0, 99) < 8);
    f.payload_len = PLEN_W'($urandom_range(0, 2047));
    f.last_frame = 1'b0;
    if (f.bad_frame || int'(f.seq_num) > last_in_order + win || xfer_finished)
      f.last_frame = ($urandom_range(0, 2) == 0);
    return f;
  endfunction

  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (calm || k < 65) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic step_row_t cfg_row(srrw_reg_t sel, logic [CFG_W-1:0] val);
    step_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.sel = sel;
    r.value = val;
    return r;
  endfunction

  function automatic step_row_t frame_row(int seq, bit bad, bit last, int plen);
    step_row_t r;
    r = '0;
    r.kind = ROW_FRAME;
    r.frame.seq_num = SEQ_W'(seq);
    r.frame.bad_frame = bad;
    r.frame.last_frame = last;
    r.frame.payload_len = PLEN_W'(plen);
    return r;
  endfunction

  function automatic step_row_t ack_row(int seq, bit bad, bit last, int plen, bit strobe,
                                        int offs, bit cmp, int len, bit done);
    step_row_t r;
    r = frame_row(seq, bad, last, plen);
    r.typed = 1'b1;
    r.want.ack_seq = SEQ_W'(seq);
    r.want.ack_negative = bad;
    r.want.store_strobe = strobe;
    r.want.store_offset = OFFS_W'(offs);
    r.want.buffer_complete = cmp;
    r.want.buffer_length = LEN_W'(len);
    r.want.transfer_done = done;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      err_count++;
    end
  endfunction

  task automatic push_frame(srrw_item_t f, logic typed, srrw_result_t want);
    srrw_result_t model;
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, f.payload_len, f.seq_num};
    in_tuser <= f.bad_frame;
    in_tlast <= f.last_frame;
    do @(posedge clk); while (!in_tready);
    model = window_step(f);
    pending_acks.push_back(typed ? want : model);
  endtask

  task automatic idle_in();
    int n;
    n = idle_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // sender holds off until every ack is back, then the register write
  task automatic write_reg(srrw_reg_t sel, logic [CFG_W-1:0] val);
    in_tvalid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_cfg(sel, val);
  endtask

  task automatic run_script();
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        write_reg(script[i].sel, script[i].value);
      end else begin
        push_frame(script[i].frame, script[i].typed, script[i].want);
        idle_in();
      end
    end
  endtask

  task automatic run_random(int n);
    repeat (n) begin
      push_frame(pick_frame(), 1'b0, '0);
      idle_in();
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rx_draw = idle_len();
      out_tready <= (rx_draw == 0);
      stall_left <= (rx_draw == 0) ? 0 : rx_draw - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res.ack_seq = out_tdata[11:0];
      seen_res.ack_negative = out_tuser;
      seen_res.store_strobe = out_tdata[12];
      seen_res.store_offset = out_tdata[34:13];
      seen_res.buffer_complete = out_tdata[35];
      seen_res.buffer_length = out_tdata[58:36];
      seen_res.transfer_done = out_tlast;
      if (pending_acks.size() == 0) begin
        $display("%0t: unexpected result, expected none, got ack_seq %0d", $realtime,
                 seen_res.ack_seq);
        err_count++;
      end else begin
        check_field("ack_seq", pending_acks[0].ack_seq, seen_res.ack_seq);
        check_field("ack_negative", pending_acks[0].ack_negative, seen_res.ack_negative);
        check_field("store_strobe", pending_acks[0].store_strobe, seen_res.store_strobe);
        check_field("store_offset", pending_acks[0].store_offset, seen_res.store_offset);
        check_field("buffer_complete", pending_acks[0].buffer_complete,
                    seen_res.buffer_complete);
        check_field("buffer_length", pending_acks[0].buffer_length, seen_res.buffer_length);
        check_field("transfer_done", pending_acks[0].transfer_done, seen_res.transfer_done);
        void'(pending_acks.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("selective_repeat_receive_window_top test failed");
      $finish;
    end
  end

  initial begin
    srrw_item_t f;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    win_reg = WS_W'(8);
    fpb_reg = FPB_W'(16);
    end_mark_seen = 1'b0;
    xfer_finished = 1'b0;
    restart_window();

    script = '{
      cfg_row(REG_FRAMES_PER_BUFFER, 13'd8191),
      ack_row(4095, 0, 1, 2047, 0, 0, 0, 0, 0),     // far beyond the window
      ack_row(0, 1, 1, 1024, 0, 0, 0, 0, 0),        // bad frame, end mark ignored
      cfg_row(REG_FRAMES_PER_BUFFER, 13'd1),
      ack_row(0, 0, 0, 2047, 1, 0, 1, 1024, 0),     // one-frame buffer
      cfg_row(REG_FRAMES_PER_BUFFER, 13'd0),
      ack_row(0, 0, 0, 0, 1, 0, 1, 1024, 0),
      cfg_row(REG_FRAMES_PER_BUFFER, 13'd16),
      cfg_row(REG_RX_WIN, 13'd0),
      ack_row(1, 0, 0, 5, 0, 0, 0, 0, 0),
      ack_row(0, 0, 0, 1, 1, 0, 0, 0, 0),
      cfg_row(REG_RX_WIN, 13'd63),
      frame_row(15, 0, 0, 100),
      frame_row(15, 0, 0, 100),                     // duplicate
      frame_row(33, 0, 0, 7),
      frame_row(32, 0, 0, 7),                       // past the frame limit
      frame_row(2, 0, 0, 1024),
      frame_row(1, 0, 0, 512),                      // ahead of the base, flagged beside 2
      frame_row(0, 0, 0, 3),
      cfg_row(REG_RX_WIN, 13'd1),
      frame_row(3, 0, 0, 1023),
      frame_row(4095, 0, 0, 1024)
    };
    run_script();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_RX_WIN, CFG_W'(WIN_SET[p]));
      write_reg(REG_FRAMES_PER_BUFFER, CFG_W'(FPB_SET[p]));
      calm = (p == 2 || p == 6);
      run_random(PHASE_ITEMS);
    end
    calm = 1'b0;

    // finish the open buffer so the end-of-transfer run starts from a clean window
    while (last_in_order != -1 || rx_flags != '0) begin
      f = '0;
      f.seq_num = SEQ_W'(last_in_order + 1);
      push_frame(f, 1'b0, '0);
      idle_in();
    end

    script = '{
      cfg_row(REG_RX_WIN, 13'd8),
      cfg_row(REG_FRAMES_PER_BUFFER, 13'd2),
      ack_row(3, 0, 0, 7, 0, 0, 0, 0, 0),           // past the limit, no end mark
      ack_row(1, 0, 0, 9, 1, 1024, 0, 0, 0),
      ack_row(1, 0, 0, 9, 0, 0, 0, 0, 0),
      ack_row(3, 0, 1, 300, 1, 3072, 0, 0, 0),      // end mark extends the limit
      ack_row(1, 0, 1, 20, 0, 0, 0, 0, 0),          // end mark on a duplicate
      ack_row(0, 0, 0, 0, 1, 0, 1, 1044, 1),
      ack_row(2, 0, 0, 0, 0, 0, 0, 0, 0),           // transfer over: ack only
      ack_row(0, 0, 1, 0, 0, 0, 0, 0, 0)
    };
    run_script();
    run_random(30);

    in_tvalid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("selective_repeat_receive_window_top test passed");
    end else begin
      $display("selective_repeat_receive_window_top test failed");
    end
    $finish;
  end

endmodule
